>>> hdl/static_loop_partition_assert.svh
// Assertion macros shared by the static loop partition RTL.
// Files that check their own logic include this header; it needs a clk and arst_n in scope.
`ifndef STATIC_LOOP_PARTITION_ASSERT_SVH
`define STATIC_LOOP_PARTITION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("static_loop_partition: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("static_loop_partition: next-cycle check failed");

`endif

>>> hdl/slp_pkg.sv
// Shared types, constants and helper functions for the static loop partition block.
// No dependencies; every other RTL file imports this package.
package slp_pkg;

	localparam int MAX_WORKERS = 64;
	localparam int DATA_W      = 64;
	localparam int HALF_W      = DATA_W / 2;
	localparam int TEAM_W      = 7;
	localparam int ID_W        = 6;
	localparam int CHUNK_W     = 63;
	localparam int DIV_STAGES  = DATA_W;
	localparam int DIV_LAST    = DIV_STAGES - 1;
	localparam int ADDR_W      = 3;
	localparam int PDATA_W     = 32;

	// Register select, taken from paddr[2]
	localparam logic REG_TEAM_SIZE  = 1'b0;
	localparam logic REG_FAIR_SPLIT = 1'b1;

	localparam logic [TEAM_W-1:0] TEAM_RESET = TEAM_W'(1);

	typedef logic [DATA_W-1:0] word_t;

	// Per-transaction context carried down the pipeline
	typedef struct packed {
		logic               even;
		logic               neg;
		logic [ID_W-1:0]    id;
		word_t              first;
		word_t              last;
		word_t              inc;
		logic [CHUNK_W-1:0] chunk;
		word_t              diff;
		word_t              size;
		word_t              cnt;
		word_t              sm;
	} job_t;

	typedef struct packed {
		word_t my_first;
		word_t my_last;
		word_t my_stride;
	} result_t;

	// Signed less-than on two's complement words
	function automatic logic s_lt(word_t a, word_t b);
		return {~a[DATA_W-1], a[DATA_W-2:0]} < {~b[DATA_W-1], b[DATA_W-2:0]};
	endfunction

	// Negate when n is set
	function automatic word_t neg_if(word_t v, logic n);
		return n ? (~v + word_t'(1)) : v;
	endfunction

	// Clamp the team size register into 1..MAX_WORKERS
	function automatic logic [TEAM_W-1:0] team_eff(logic [TEAM_W-1:0] raw);
		logic [TEAM_W-1:0] t;
		if (raw == '0) begin
			t = TEAM_W'(1);
		end else if (raw > TEAM_W'(MAX_WORKERS)) begin
			t = TEAM_W'(MAX_WORKERS);
		end else begin
			t = raw;
		end
		return t;
	endfunction

endpackage

>>> hdl/slp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with context sideband.
// Depends on slp_pkg; a zero divisor gives a zero quotient.
module slp_div import slp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  word_t in_num,
	input  word_t in_den,
	input  job_t  in_job,
	output logic  out_valid,
	output word_t out_quo,
	output job_t  out_job
);

	logic  valid_s [DIV_STAGES];
	word_t rem_s   [DIV_STAGES];
	word_t quo_s   [DIV_STAGES];
	word_t den_s   [DIV_STAGES];
	job_t  job_s   [DIV_STAGES];

	logic  pv_w [DIV_STAGES];
	word_t pr_w [DIV_STAGES];
	word_t pn_w [DIV_STAGES];
	word_t pd_w [DIV_STAGES];
	job_t  pj_w [DIV_STAGES];
	word_t rem_d [DIV_STAGES];
	word_t quo_d [DIV_STAGES];

	// Select each stage's source: the ports for the first, the stage before otherwise
	always_comb begin
		pv_w[0] = in_valid;
		pr_w[0] = '0;
		pn_w[0] = in_num;
		pd_w[0] = in_den;
		pj_w[0] = in_job;
		for (int k = 1; k < DIV_STAGES; k++) begin
			pv_w[k] = valid_s[k-1];
			pr_w[k] = rem_s[k-1];
			pn_w[k] = quo_s[k-1];
			pd_w[k] = den_s[k-1];
			pj_w[k] = job_s[k-1];
		end
	end

	// Shift in one dividend bit, trial subtract, shift in one quotient bit
	always_comb begin
		logic [DATA_W:0] tr;
		logic            qb;
		for (int k = 0; k < DIV_STAGES; k++) begin
			tr       = {pr_w[k], pn_w[k][DATA_W-1]};
			qb       = (tr >= {1'b0, pd_w[k]});
			rem_d[k] = qb ? DATA_W'(tr - {1'b0, pd_w[k]}) : tr[DATA_W-1:0];
			quo_d[k] = {pn_w[k][DATA_W-2:0], qb};
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k] <= pv_w[k];
			end
		end
	end

	// Advance data
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k] <= rem_d[k];
				quo_s[k] <= quo_d[k];
				den_s[k] <= pd_w[k];
				job_s[k] <= pj_w[k];
			end
		end
	end

	assign out_valid = valid_s[DIV_LAST];
	assign out_quo   = (den_s[DIV_LAST] == '0) ? '0 : quo_s[DIV_LAST];
	assign out_job   = job_s[DIV_LAST];

endmodule

>>> hdl/slp_mullo.sv
// Two-stage multiplier giving the low word of a full-width product, built from 32x32 pieces.
// Depends on slp_pkg; carries no valid, the caller keeps its context aligned.
module slp_mullo import slp_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t a,
	input  word_t b,
	output word_t p
);

	word_t               ll_s1;
	logic [HALF_W-1:0]   lh_s1;
	logic [HALF_W-1:0]   hl_s1;

	// Form partial products; cross terms only need their low half
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
			lh_s1 <= HALF_W'(a[HALF_W-1:0] * b[DATA_W-1:HALF_W]);
			hl_s1 <= HALF_W'(a[DATA_W-1:HALF_W] * b[HALF_W-1:0]);
		end
	end

	// Sum the pieces
	always_ff @(posedge clk) begin
		if (en) begin
			p <= ll_s1 + {HALF_W'(lh_s1 + hl_s1), {HALF_W{1'b0}}};
		end
	end

endmodule

>>> hdl/slp_skid.sv
// Output register with a skid entry, parting the pipeline from the result channel.
// Depends on slp_pkg and the assertion macro header.
`include "static_loop_partition_assert.svh"

module slp_skid import slp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  result_t in_res,
	output logic    adv,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    slot_free;

	assign adv       = !skid_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Control: load output from skid first, else from the pipeline; park on stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && adv) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Data
	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && adv) begin
			skid_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`SLP_ASSERT_SAME(a_skid_implies_out, skid_valid_q, out_valid_q)
	`SLP_ASSERT_NEXT(a_skid_fill, out_valid_q && out_stall && in_valid && !skid_valid_q, skid_valid_q)
	`SLP_ASSERT_NEXT(a_skid_drain, skid_valid_q && !out_stall, out_valid_q && !skid_valid_q)

endmodule

>>> hdl/static_loop_partition.sv
// Static loop partition: computes one worker's first index, first-chunk end and stride for a
// statically scheduled loop, in chunked or even mode. One transaction is accepted per cycle while
// in_stall is low, and its result passes through the two 64-stage pipelined dividers (trip count
// by step, then trip count by team size), fifteen context and multiply stages and the output
// register. in_stall rises only while the output skid entry is full. Depends on slp_pkg, slp_div,
// slp_mullo and slp_skid. The worker count (offset 0x0) and fair_split (offset 0x4) are APB
// registers.
module static_loop_partition import slp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                even_mode,
	input  logic [ID_W-1:0]     worker_index,
	input  logic signed [DATA_W-1:0] loop_first,
	input  logic signed [DATA_W-1:0] loop_last,
	input  logic signed [DATA_W-1:0] step,
	input  logic [CHUNK_W-1:0]  chunk_size,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [DATA_W-1:0] my_first,
	output logic signed [DATA_W-1:0] my_last,
	output logic signed [DATA_W-1:0] my_stride
);

	logic [TEAM_W-1:0] workers_q;
	logic              fair_split_q;
	logic [TEAM_W-1:0] teff;
	word_t             teff_w;
	logic              cfg_wr;
	logic              adv;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			workers_q    <= TEAM_RESET;
			fair_split_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TEAM_SIZE:  workers_q    <= pwdata[TEAM_W-1:0];
				REG_FAIR_SPLIT: fair_split_q <= pwdata[0];
				default:        workers_q    <= workers_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TEAM_SIZE:  prdata = {{(PDATA_W-TEAM_W){1'b0}}, workers_q};
			REG_FAIR_SPLIT: prdata = {{(PDATA_W-1){1'b0}}, fair_split_q};
			default:        prdata = '0;
		endcase
	end

	assign teff   = team_eff(workers_q);
	assign teff_w = {{(DATA_W-TEAM_W){1'b0}}, teff};
	assign in_stall = !adv;

	// Pipeline registers
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic  v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	job_t  job_s1, job_s2, job_s3, job_s4, job_s5, job_s6, job_s7, job_s8;
	job_t  job_s9, job_s10, job_s11, job_s12, job_s13, job_s14, job_s15;
	word_t num_s2, den_s2, n2_s4, num_s5, den_s5;
	word_t ct_s7, idc_s7, rem_s8, idc_s8, adj_s9, idc_s9;
	logic  plus_s9;
	word_t idx_s10, cm1_s10, idx_s11, c3_s11;
	word_t lower_s14, end_s14, stride_s14, e1_s14, e2_s14, sws_s14;
	word_t lower_s15, end_s15, stride_s15, e1_s15, e2_s15, sws_s15;
	logic  cond_s15, take_end_s15;

	logic  d1_valid, d2_valid;
	word_t d1_quo, d2_quo;
	job_t  d1_job, d2_job;
	word_t p1, p2, p3;

	job_t  j_in, j2, j3, j5, j6;
	word_t size3, n2, cq6, idw9;
	logic  fsel9, up15;
	result_t res_d;

	// Valid bits advance together with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0; v_s5  <= 1'b0;
			v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0; v_s9  <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid; v_s2  <= v_s1;  v_s3  <= d1_valid; v_s4  <= v_s3;
			v_s5  <= v_s4;     v_s6  <= d2_valid; v_s7 <= v_s6;  v_s8  <= v_s7;
			v_s9  <= v_s8;     v_s10 <= v_s9;  v_s11 <= v_s10; v_s12 <= v_s11;
			v_s13 <= v_s12;    v_s14 <= v_s13; v_s15 <= v_s14;
		end
	end

	// Stage 1: capture transaction, form last - first
	always_comb begin
		j_in       = '0;
		j_in.even  = even_mode;
		j_in.id    = worker_index;
		j_in.first = loop_first;
		j_in.last  = loop_last;
		j_in.inc   = step;
		j_in.chunk = chunk_size;
		j_in.diff  = loop_last - loop_first;
	end

	// Stage 2: magnitudes for the trip-count divide, chunked stride multiple
	always_comb begin
		j2     = job_s1;
		j2.neg = job_s1.diff[DATA_W-1] ^ job_s1.inc[DATA_W-1];
		j2.sm  = {1'b0, job_s1.chunk} * teff_w;
	end

	// Stage 3: trip count = quotient + 1 with sign restored
	always_comb begin
		j3       = d1_job;
		size3    = j3.neg ? (~d1_quo + word_t'(2)) : (d1_quo + word_t'(1));
		j3.size  = size3;
	end

	// Stage 4: dividend for the per-worker count
	assign n2 = job_s3.size + (fair_split_q ? '0 : (teff_w - word_t'(1)));

	// Stage 5: magnitude for the team divide
	always_comb begin
		j5     = job_s4;
		j5.neg = n2_s4[DATA_W-1];
	end

	// Stage 6: per-worker count; chunked mode uses chunk size
	always_comb begin
		j6     = d2_job;
		cq6    = neg_if(d2_quo, d2_job.neg);
		j6.cnt = d2_job.even ? cq6 : {1'b0, d2_job.chunk};
		j6.sm  = d2_job.even ? d2_job.size : d2_job.sm;
	end

	// Stage 9: remainder adjustment for fair split
	assign idw9  = {{(DATA_W-ID_W){1'b0}}, job_s8.id};
	assign fsel9 = job_s8.even && fair_split_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1  <= j_in;
			job_s2  <= j2;
			num_s2  <= neg_if(job_s1.diff, job_s1.diff[DATA_W-1]);
			den_s2  <= neg_if(job_s1.inc, job_s1.inc[DATA_W-1]);
			job_s3  <= j3;
			job_s4  <= job_s3;
			n2_s4   <= n2;
			job_s5  <= j5;
			num_s5  <= neg_if(n2_s4, n2_s4[DATA_W-1]);
			den_s5  <= teff_w;
			job_s6  <= j6;
			// Stage 7: narrow products
			job_s7  <= job_s6;
			ct_s7   <= job_s6.cnt * teff_w;
			idc_s7  <= {{(DATA_W-ID_W){1'b0}}, job_s6.id} * job_s6.cnt;
			// Stage 8: remainder
			job_s8  <= job_s7;
			rem_s8  <= job_s7.size - ct_s7;
			idc_s8  <= idc_s7;
			job_s9  <= job_s8;
			adj_s9  <= fsel9 ? (s_lt(rem_s8, idw9) ? rem_s8 : idw9) : '0;
			plus_s9 <= fsel9 && s_lt(idw9, rem_s8);
			idc_s9  <= idc_s8;
			// Stage 10: iteration offset, count minus one
			job_s10 <= job_s9;
			idx_s10 <= idc_s9 + adj_s9;
			cm1_s10 <= plus_s9 ? job_s9.cnt : (job_s9.cnt - word_t'(1));
			// Stage 11: offset of the chunk's last iteration
			job_s11 <= job_s10;
			idx_s11 <= idx_s10;
			c3_s11  <= idx_s10 + cm1_s10;
			// Stages 12-13: wide multiplies in flight
			job_s12 <= job_s11;
			job_s13 <= job_s12;
			// Stage 14: index values
			job_s14    <= job_s13;
			lower_s14  <= job_s13.first + p1;
			end_s14    <= job_s13.first + p3;
			stride_s14 <= p2;
			e1_s14     <= job_s13.first - job_s13.inc;
			e2_s14     <= job_s13.first - {job_s13.inc[DATA_W-2:0], 1'b0};
			sws_s14    <= (!job_s13.inc[DATA_W-1] && job_s13.inc != '0) ?
				(job_s13.diff + word_t'(1)) : (job_s13.diff - word_t'(1));
			// Stage 15: range tests
			job_s15      <= job_s14;
			lower_s15    <= lower_s14;
			end_s15      <= end_s14;
			stride_s15   <= stride_s14;
			e1_s15       <= e1_s14;
			e2_s15       <= e2_s14;
			sws_s15      <= sws_s14;
			cond_s15     <= up15 ? !s_lt(job_s14.last, lower_s14) : !s_lt(lower_s14, job_s14.last);
			take_end_s15 <= up15 ? !s_lt(job_s14.last, end_s14) : !s_lt(end_s14, job_s14.last);
		end
	end

	assign up15 = !job_s14.inc[DATA_W-1];

	// Trip count divide
	slp_div u_div_trip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.in_num    (num_s2),
		.in_den    (den_s2),
		.in_job    (job_s2),
		.out_valid (d1_valid),
		.out_quo   (d1_quo),
		.out_job   (d1_job)
	);

	// Per-worker count divide
	slp_div u_div_team (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_num    (num_s5),
		.in_den    (den_s5),
		.in_job    (job_s5),
		.out_valid (d2_valid),
		.out_quo   (d2_quo),
		.out_job   (d2_job)
	);

	// Scale offsets and stride by the step
	slp_mullo u_mul_lower (.clk(clk), .en(adv), .a(idx_s11),     .b(job_s11.inc), .p(p1));
	slp_mullo u_mul_stride(.clk(clk), .en(adv), .a(job_s11.sm),  .b(job_s11.inc), .p(p2));
	slp_mullo u_mul_end   (.clk(clk), .en(adv), .a(c3_s11),      .b(job_s11.inc), .p(p3));

	// Final select: single worker, own range, or empty range
	always_comb begin
		if (teff == TEAM_W'(1)) begin
			res_d.my_first  = job_s15.first;
			res_d.my_last   = job_s15.last;
			res_d.my_stride = sws_s15;
		end else if (cond_s15) begin
			res_d.my_first  = lower_s15;
			res_d.my_last   = take_end_s15 ? end_s15 : job_s15.last;
			res_d.my_stride = stride_s15;
		end else begin
			res_d.my_first  = e1_s15;
			res_d.my_last   = e2_s15;
			res_d.my_stride = job_s15.inc;
		end
	end

	result_t out_res;

	slp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s15),
		.in_res    (res_d),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign my_first  = out_res.my_first;
	assign my_last   = out_res.my_last;
	assign my_stride = out_res.my_stride;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for static_loop_partition: random and directed loop partitions checked against
// an in-bench predictor. Depends on slp_pkg and the static_loop_partition RTL.
module tb;
	import slp_pkg::*;

	typedef struct {
		logic        even;
		logic [5:0]  id;
		logic [63:0] first;
		logic [63:0] last;
		logic [63:0] inc;
		logic [62:0] chunk;
	} loop_item_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] str;
	} share_t;

	localparam int LATENCY = 200;
	localparam logic [ADDR_W-1:0] ADDR_TEAM = 3'h0;
	localparam logic [ADDR_W-1:0] ADDR_FAIR = 3'h4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic even_mode = 1'b0;
	logic [ID_W-1:0] worker_index = '0;
	logic signed [63:0] loop_first = '0, loop_last = '0, step = '0;
	logic [CHUNK_W-1:0] chunk_size = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [63:0] my_first, my_last, my_stride;

	logic [6:0] team_reg = 7'd1;
	logic fair_reg = 1'b0;

	loop_item_t pending_items[$];
	share_t expected_shares[$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off = 0;

	static_loop_partition i_dut (.*);

	always #2 clk = ~clk;

	// Signed helpers at 64 bits
	function automatic bit lt_s(logic [63:0] a, logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
		logic [63:0] ma, mb, q;
		if (b == 0) return 64'd0;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	// Compute one worker's share of the loop
	function automatic share_t partition_share(loop_item_t it);
		share_t r;
		logic [63:0] t, chunk, size, rem, idx, fin, id;
		logic [63:0] mn;
		bit up;
		t = 64'(team_reg);
		if (t == 0) t = 1;
		if (t > 64) t = 64;
		up = !it.inc[63];
		chunk = {1'b0, it.chunk};
		id = 64'(it.id);
		if (t == 1) begin
			r.lo = it.first;
			r.hi = it.last;
			r.str = (up && it.inc != 0) ? it.last - it.first + 1 : it.last - it.first - 1;
			return r;
		end
		if (it.even) begin
			size = div_trunc(it.last - it.first, it.inc) + 1;
			if (!fair_reg) begin
				chunk = div_trunc(size + t - 1, t);
				r.lo = it.first + id * chunk * it.inc;
			end else begin
				chunk = div_trunc(size, t);
				rem = size - chunk * t;
				mn = lt_s(rem, id) ? rem : id;
				idx = mn * (chunk + 1);
				if (lt_s(rem, id)) idx += (id - rem) * chunk;
				r.lo = it.first + idx * it.inc;
				if (lt_s(id, rem)) chunk += 1;
			end
			r.str = size * it.inc;
		end else begin
			r.str = chunk * it.inc;
			r.lo = it.first + id * r.str;
			r.str = r.str * t;
		end
		if (up ? !lt_s(it.last, r.lo) : !lt_s(r.lo, it.last)) begin
			fin = r.lo + (chunk - 1) * it.inc;
			if (up) r.hi = lt_s(it.last, fin) ? it.last : fin;
			else r.hi = lt_s(fin, it.last) ? it.last : fin;
		end else begin
			r.lo = it.first - it.inc;
			r.hi = r.lo - it.inc;
			r.str = it.inc;
		end
		return r;
	endfunction

	// Driver: present queued transactions, advance on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_shares.push_back(partition_share(pending_items.pop_front()));
			end
			if (!(in_valid && in_stall)) begin
				if (pending_items.size() > 0 && ($urandom_range(99) >= send_idle_pct)
						&& !(in_valid && !in_stall && pending_items.size() == 0)) begin
					in_valid <= 1'b1;
					even_mode <= pending_items[0].even;
					worker_index <= pending_items[0].id;
					loop_first <= pending_items[0].first;
					loop_last <= pending_items[0].last;
					step <= pending_items[0].inc;
					chunk_size <= pending_items[0].chunk;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: long hold-off or random
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		share_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_shares.size() == 0) begin
				$display("%0t: unexpected result %h %h %h", $time, my_first, my_last, my_stride);
				errors++;
			end else begin
				e = expected_shares.pop_front();
				if (my_first !== e.lo) begin
					$display("%0t: my_first exp %h got %h", $time, e.lo, my_first);
					errors++;
				end
				if (my_last !== e.hi) begin
					$display("%0t: my_last exp %h got %h", $time, e.hi, my_last);
					errors++;
				end
				if (my_stride !== e.str) begin
					$display("%0t: my_stride exp %h got %h", $time, e.str, my_stride);
					errors++;
				end
			end
		end
	end

	task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (a == ADDR_TEAM) team_reg = d[6:0];
		else fair_reg = d[0];
	endtask

	// Wait until the block has drained, then its latency
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_shares.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rnd_small();
		return 64'($signed($urandom_range(400)) - 200);
	endfunction

	function automatic loop_item_t rand_item();
		loop_item_t it;
		int k;
		k = $urandom_range(9);
		it.even = 1'($urandom_range(1));
		it.id = (team_reg >= 1 && team_reg <= 64 && $urandom_range(3) != 0)
			? 6'($urandom_range(team_reg - 1)) : 6'($urandom());
		if (k < 7) begin
			it.first = rnd_small();
			it.inc = 64'($signed($urandom_range(8)) - 4);
			if (it.inc == 0) it.inc = 1;
			it.last = it.first + it.inc * 64'($urandom_range(300)) - 64'($urandom_range(2));
			it.chunk = 63'($urandom_range(1, 20));
		end else begin
			it.first = rnd64();
			it.last = rnd64();
			it.inc = (k == 9) ? 64'd0 : rnd64();
			it.chunk = (k == 9) ? 63'd0 : 63'(rnd64());
		end
		return it;
	endfunction

	task automatic push(logic e, logic [5:0] id, logic [63:0] f, logic [63:0] l,
			logic [63:0] s, logic [62:0] c);
		loop_item_t it;
		it.even = e; it.id = id; it.first = f; it.last = l; it.inc = s; it.chunk = c;
		pending_items.push_back(it);
	endtask

	initial begin
		int cfg_t[6] = '{1, 0, 64, 127, 4, 7};
		logic [63:0] mn;
		mn = 64'h8000_0000_0000_0000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single worker pass-through, then team of 4 corner cases
		push(0, 0, 0, 99, 1, 10);
		push(1, 0, 100, 0, -1, 1);
		push(0, 0, 5, 5, 0, 1);
		drain();
		reg_write(ADDR_TEAM, 4);
		reg_write(ADDR_FAIR, 1);
		push(1, 0, 0, 9, 1, 1);
		push(1, 1, 0, 9, 1, 1);
		push(1, 3, 0, 9, 1, 1);
		push(1, 63, 0, 9, 1, 1);
		push(0, 2, 0, 100, 3, 5);
		push(0, 3, 0, 5, 1, 10);
		push(0, 1, 10, -10, -2, 3);
		push(1, 2, 0, 9, 0, 1);
		push(0, 1, 0, 9, 1, 0);
		push(1, 1, mn, 64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 63'h7fff_ffff_ffff_ffff);
		push(1, 0, 0, mn, 64'hffff_ffff_ffff_ffff, 1);
		push(1, 2, 10, 0, 1, 1);
		drain();
		reg_write(ADDR_FAIR, 0);
		push(1, 1, 0, 9, 1, 1);
		push(1, 2, -5, -100, -7, 1);
		drain();

		// Random phases over several team settings and idling patterns; the hold-off
		// phase offers more transactions than the pipeline holds so the input stalls
		for (int p = 0; p < 12; p++) begin
			reg_write(ADDR_TEAM, cfg_t[p % 6]);
			reg_write(ADDR_FAIR, p[0]);
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 78; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 78; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			if (p == 4) hold_off = 400;
			for (int n = 0; n < ((p == 4) ? 300 : 48); n++) pending_items.push_back(rand_item());
			drain();
		end
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hard stop
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

>>> static_loop_partition.f
+incdir+hdl
hdl/slp_pkg.sv
hdl/slp_div.sv
hdl/slp_mullo.sv
hdl/slp_skid.sv
hdl/static_loop_partition.sv
test/tb.sv
